[design/bra_pkg.sv]
// Shared types and constants of the bitmap rectangle allocator.
`default_nettype none
package bra_pkg;

  localparam int RECT_W     = 11;
  localparam int IDX_W      = 7;
  localparam int COORD_W    = 10;
  localparam int ASIZE_W    = 11;
  localparam int EXP_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int OCC_WORD_W = 32;
  localparam int OCC_BIT_W  = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [EXP_W-1:0] DEF_LOG2_RESET = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_DEF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_HEIGHT = 1'b1;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 3'd0,
    ST_NO_ROOM  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_DEL_IDLE = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } occ_cmd_t;

  typedef struct packed {
    logic ent_rd;
    logic ent_wr;
    logic stk_rd;
    logic stk_wr;
  } tbl_cmd_t;

endpackage
`default_nettype wire

[design/bra_if.sv]
// Input and result channel interfaces of the bitmap rectangle allocator.
`default_nettype none
interface bra_in_if import bra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [RECT_W-1:0]        rect_width;
  logic [RECT_W-1:0]        rect_height;
  logic signed [IDX_W-1:0]  entry_index;
  modport source(output valid, command, rect_width, rect_height, entry_index, input ready);
  modport sink(input valid, command, rect_width, rect_height, entry_index, output ready);
endinterface

interface bra_out_if import bra_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [IDX_W-1:0]  placed_index;
  logic [COORD_W-1:0]       begin_x;
  logic [COORD_W-1:0]       begin_y;
  logic [COORD_W-1:0]       end_x;
  logic [COORD_W-1:0]       end_y;
  logic [ASIZE_W-1:0]       atlas_width;
  logic [ASIZE_W-1:0]       atlas_height;
  logic                     atlas_idle;
  modport source(output valid, status, placed_index, begin_x, begin_y, end_x, end_y,
                 atlas_width, atlas_height, atlas_idle, input ready);
  modport sink(input valid, status, placed_index, begin_x, begin_y, end_x, end_y,
               atlas_width, atlas_height, atlas_idle, output ready);
endinterface
`default_nettype wire

[design/bra_occ_mem.sv]
// Occupancy bitmap memory, 32 pixels a word, with a clearing sweep after reset.
`default_nettype none
module bra_occ_mem import bra_pkg::*; #(
  parameter int ADDR_W = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire occ_cmd_t              cmd,
  input  wire logic [ADDR_W-1:0]     addr,
  input  wire logic [OCC_WORD_W-1:0] wdata,
  output logic [OCC_WORD_W-1:0]      rdata,
  output logic                       busy
);

  logic [OCC_WORD_W-1:0] mem [2**ADDR_W];
  logic [OCC_WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0]     clr_ptr_r;
  logic                  busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_ptr_r <= '0;
    end else if (busy_r) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
      if (&clr_ptr_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_ptr_r] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule
`default_nettype wire

[design/bra_tbl.sv]
// Entry corner table and freed index stack memories.
`default_nettype none
module bra_tbl import bra_pkg::*; #(
  parameter int ENT_W = 40,
  parameter int IW    = 6
) (
  input  wire logic             clk,
  input  wire tbl_cmd_t         cmd,
  input  wire logic [IW-1:0]    ent_addr,
  input  wire logic [ENT_W-1:0] ent_wdata,
  output logic [ENT_W-1:0]      ent_rdata,
  input  wire logic [IW-1:0]    stk_addr,
  input  wire logic [IW-1:0]    stk_wdata,
  output logic [IW-1:0]         stk_rdata
);

  logic [ENT_W-1:0] ent_mem [2**IW];
  logic [IW-1:0]    stk_mem [2**IW];
  logic [ENT_W-1:0] ent_rdata_r;
  logic [IW-1:0]    stk_rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.ent_wr) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (cmd.ent_rd) begin
      ent_rdata_r <= ent_mem[ent_addr];
    end
    if (cmd.stk_wr) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    if (cmd.stk_rd) begin
      stk_rdata_r <= stk_mem[stk_addr];
    end
  end

  assign ent_rdata = ent_rdata_r;
  assign stk_rdata = stk_rdata_r;

endmodule
`default_nettype wire

[design/bitmap_rectangle_allocator.sv]
// First-fit rectangle allocator over a pixel occupancy bitmap held in one word memory.
// An add runs a raster scan that tests pixels and tries positions in turn, then marks the
// pixels of the rectangle; a delete frees the pixels of its entry. Throughput is one item
// at a time; the bitmap port sets the pace.
// Reset: synchronous, active low; a clearing sweep then runs over every word of the bitmap,
// during which no item is taken.
`default_nettype none
module bitmap_rectangle_allocator import bra_pkg::*; #(
  parameter int MAX_SIZE_LOG2 = 10,
  parameter int MAX_ENTRIES   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bra_in_if.sink                    in_ch,
  bra_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [EXP_W-1:0]     cfg_data
);

  localparam int M     = MAX_SIZE_LOG2;
  localparam int EW    = (M + 2 > 12) ? M + 2 : 12;
  localparam int PW    = (2 * M + 1 > 22) ? 2 * M + 1 : 22;
  localparam int FCW   = 2 * M + 1;
  localparam int PAW   = 2 * M;
  localparam int OWA   = PAW - OCC_BIT_W;
  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CNW   = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = 4 * M;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_POS, S_PRD, S_PCHK, S_ALLOC, S_POP, S_RD, S_WR,
    S_AFIN, S_DCHK, S_DENT, S_DFIN, S_EMIT
  } state_t;

  state_t              state_r;
  logic                idle_r;
  logic [EXP_W-1:0]    def_w_r, def_h_r, we_r, he_r;
  logic [FCW-1:0]      free_r;
  logic                cmd_r;
  logic [RECT_W-1:0]   w_r, h_r;
  logic [IDX_W-1:0]    raw_r;
  logic [EW-1:0]       x_r, y_r, xe_r, ye_r, r_r, c_r;
  logic [OWA-1:0]      wa_r;
  logic [OCC_BIT_W-1:0] bsel_r;
  logic [IW-1:0]       idx_r;
  logic [CNW-1:0]      stk_cnt_r, issued_r;
  logic [MAX_ENTRIES-1:0] valid_r;
  status_t             res_r;

  logic                   out_valid_r;
  status_t                o_status_r;
  logic [IDX_W-1:0]       o_idx_r;
  logic [COORD_W-1:0]     o_bx_r, o_by_r, o_ex_r, o_ey_r;
  logic [ASIZE_W-1:0]     o_aw_r, o_ah_r;
  logic                   o_idle_r;

  occ_cmd_t              occ_cmd;
  logic [OWA-1:0]        occ_addr;
  logic [OCC_WORD_W-1:0] occ_wdata, occ_rdata;
  logic                  occ_busy;
  tbl_cmd_t              tbl_cmd;
  logic [IW-1:0]         ent_addr;
  logic [IW-1:0]         stk_addr;
  logic [ENT_W-1:0]      ent_rdata;
  logic [IW-1:0]         stk_rdata;

  function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
    return (32'(e) > M) ? EXP_W'(M) : e;
  endfunction

  function automatic logic [EXP_W-1:0] grow_exp(input logic [EXP_W-1:0] d,
                                                input logic [RECT_W-1:0] s);
    logic [EXP_W-1:0] dc;
    logic [EXP_W-1:0] p;
    dc = clamp_exp(d);
    p  = EXP_W'(M);
    if (EW'(s) <= (EW'(1) << dc)) begin
      p = dc;
    end else begin
      for (int i = M; i >= 0; i--) begin
        if (EW'(s) <= (EW'(1) << i)) begin
          p = EXP_W'(i);
        end
      end
    end
    return p;
  endfunction

  logic [EXP_W-1:0] cur_we, cur_he, gw, gh;
  logic [EW-1:0]    aw, ah, xl, yl;
  logic [FCW-1:0]   full;
  logic [PW-1:0]    area;
  logic [PAW-1:0]   pix;
  logic             in_ready, in_acc, last_c, last_r, occ_bit, del_bad, emit_go;

  assign cur_we = idle_r ? clamp_exp(def_w_r) : we_r;
  assign cur_he = idle_r ? clamp_exp(def_h_r) : he_r;
  assign gw     = grow_exp(def_w_r, in_ch.rect_width);
  assign gh     = grow_exp(def_h_r, in_ch.rect_height);
  assign aw     = EW'(1) << we_r;
  assign ah     = EW'(1) << he_r;
  assign full   = FCW'(1) << (5'(we_r) + 5'(he_r));
  assign area   = PW'(w_r) * PW'(h_r);
  assign xl     = x_r + EW'(w_r) - EW'(1);
  assign yl     = y_r + EW'(h_r) - EW'(1);
  assign pix    = (PAW'(r_r) << we_r) | PAW'(c_r);
  assign occ_bit = occ_rdata[bsel_r];
  assign last_c = (state_r == S_PCHK) ? (c_r == xl) : (c_r == xe_r);
  assign last_r = (state_r == S_PCHK) ? (r_r == yl) : (r_r == ye_r);
  assign del_bad = raw_r[IDX_W-1] || (32'(raw_r) >= MAX_ENTRIES) ||
                   !valid_r[IW'(raw_r)] || idle_r;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  // the entry read for a delete goes out before idx_r is loaded
  assign ent_addr = (state_r == S_DCHK) ? IW'(raw_r) : idx_r;

  assign in_ready = (state_r == S_IDLE) && !occ_busy;
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    occ_cmd   = '0;
    occ_addr  = pix[PAW-1:OCC_BIT_W];
    occ_wdata = occ_rdata;
    tbl_cmd   = '0;
    stk_addr  = IW'(stk_cnt_r);
    case (state_r)
      S_PRD, S_RD: occ_cmd.rd = 1'b1;
      S_WR: begin
        occ_cmd.wr = 1'b1;
        occ_addr   = wa_r;
        occ_wdata[bsel_r] = (cmd_r == CMD_ADD);
      end
      S_ALLOC: begin
        if (stk_cnt_r != '0) begin
          tbl_cmd.stk_rd = 1'b1;
          stk_addr       = IW'(stk_cnt_r - 1'b1);
        end
      end
      S_AFIN: tbl_cmd.ent_wr = 1'b1;
      S_DCHK: tbl_cmd.ent_rd = !del_bad;
      S_DFIN: tbl_cmd.stk_wr = (32'(stk_cnt_r) < MAX_ENTRIES);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idle_r      <= 1'b1;
      def_w_r     <= DEF_LOG2_RESET;
      def_h_r     <= DEF_LOG2_RESET;
      free_r      <= '0;
      stk_cnt_r   <= '0;
      issued_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEF_WIDTH:  def_w_r <= cfg_data;
          REG_DEF_HEIGHT: def_h_r <= cfg_data;
          default: ;
        endcase
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_ch.command;
            w_r   <= in_ch.rect_width;
            h_r   <= in_ch.rect_height;
            raw_r <= in_ch.entry_index;
            if (in_ch.command == CMD_ADD) begin
              if (idle_r) begin
                idle_r <= 1'b0;
                we_r   <= gw;
                he_r   <= gh;
                free_r <= FCW'(1) << (5'(gw) + 5'(gh));
              end
              state_r <= S_CHK;
            end else begin
              state_r <= S_DCHK;
            end
          end
        end
        S_CHK: begin
          x_r <= '0;
          y_r <= '0;
          if (w_r == '0 || h_r == '0 || area > PW'(free_r) ||
              EW'(w_r) > aw || EW'(h_r) > ah) begin
            res_r   <= ST_NO_ROOM;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_POS;
          end
        end
        S_POS: begin
          if (y_r + EW'(h_r) > ah) begin
            res_r   <= ST_NO_ROOM;
            state_r <= S_EMIT;
          end else if (x_r + EW'(w_r) > aw) begin
            x_r <= '0;
            y_r <= y_r + 1'b1;
          end else begin
            r_r     <= y_r;
            c_r     <= x_r;
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          bsel_r  <= pix[OCC_BIT_W-1:0];
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (occ_bit) begin
            // skip past the clashing column
            x_r     <= c_r + 1'b1;
            state_r <= S_POS;
          end else if (!last_c) begin
            c_r     <= c_r + 1'b1;
            state_r <= S_PRD;
          end else if (!last_r) begin
            c_r     <= x_r;
            r_r     <= r_r + 1'b1;
            state_r <= S_PRD;
          end else begin
            xe_r    <= xl;
            ye_r    <= yl;
            state_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          r_r <= y_r;
          c_r <= x_r;
          if (stk_cnt_r != '0) begin
            stk_cnt_r <= stk_cnt_r - 1'b1;
            state_r   <= S_POP;
          end else if (32'(issued_r) < MAX_ENTRIES) begin
            idx_r    <= IW'(issued_r);
            issued_r <= issued_r + 1'b1;
            state_r  <= S_RD;
          end else begin
            res_r   <= ST_FULL;
            state_r <= S_EMIT;
          end
        end
        S_POP: begin
          idx_r   <= stk_rdata;
          state_r <= S_RD;
        end
        S_RD: begin
          wa_r    <= pix[PAW-1:OCC_BIT_W];
          bsel_r  <= pix[OCC_BIT_W-1:0];
          state_r <= S_WR;
        end
        S_WR: begin
          if (cmd_r == CMD_DELETE) begin
            free_r <= free_r + 1'b1;
          end
          if (!last_c) begin
            c_r     <= c_r + 1'b1;
            state_r <= S_RD;
          end else if (!last_r) begin
            c_r     <= x_r;
            r_r     <= r_r + 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= (cmd_r == CMD_ADD) ? S_AFIN : S_DFIN;
          end
        end
        S_AFIN: begin
          free_r         <= free_r - FCW'(area);
          valid_r[idx_r] <= 1'b1;
          res_r          <= ST_PLACED;
          state_r        <= S_EMIT;
        end
        S_DCHK: begin
          if (del_bad) begin
            res_r   <= ST_DELETED;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= IW'(raw_r);
            state_r <= S_DENT;
          end
        end
        S_DENT: begin
          x_r     <= EW'(ent_rdata[4*M-1:3*M]);
          y_r     <= EW'(ent_rdata[3*M-1:2*M]);
          xe_r    <= EW'(ent_rdata[2*M-1:M]);
          ye_r    <= EW'(ent_rdata[M-1:0]);
          c_r     <= EW'(ent_rdata[4*M-1:3*M]);
          r_r     <= EW'(ent_rdata[3*M-1:2*M]);
          state_r <= S_RD;
        end
        S_DFIN: begin
          if (free_r >= full) begin
            // every pixel free again: release the atlas
            idle_r    <= 1'b1;
            free_r    <= '0;
            stk_cnt_r <= '0;
            issued_r  <= '0;
            valid_r   <= '0;
            res_r     <= ST_DEL_IDLE;
          end else begin
            valid_r[idx_r] <= 1'b0;
            if (32'(stk_cnt_r) < MAX_ENTRIES) begin
              stk_cnt_r <= stk_cnt_r + 1'b1;
            end
            res_r <= ST_DELETED;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            o_status_r  <= res_r;
            o_idle_r    <= idle_r;
            o_aw_r      <= ASIZE_W'(EW'(1) << cur_we);
            o_ah_r      <= ASIZE_W'(EW'(1) << cur_he);
            if (res_r == ST_PLACED) begin
              o_idx_r <= IDX_W'(idx_r);
              o_bx_r  <= COORD_W'(x_r);
              o_by_r  <= COORD_W'(y_r);
              o_ex_r  <= COORD_W'(xe_r);
              o_ey_r  <= COORD_W'(ye_r);
            end else begin
              o_idx_r <= '1;
              o_bx_r  <= '0;
              o_by_r  <= '0;
              o_ex_r  <= '0;
              o_ey_r  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  bra_occ_mem #(.ADDR_W(OWA)) u_occ (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (occ_cmd),
    .addr  (occ_addr),
    .wdata (occ_wdata),
    .rdata (occ_rdata),
    .busy  (occ_busy)
  );

  bra_tbl #(.ENT_W(ENT_W), .IW(IW)) u_tbl (
    .clk       (clk),
    .cmd       (tbl_cmd),
    .ent_addr  (ent_addr),
    .ent_wdata ({M'(x_r), M'(y_r), M'(xe_r), M'(ye_r)}),
    .ent_rdata (ent_rdata),
    .stk_addr  (stk_addr),
    .stk_wdata (idx_r),
    .stk_rdata (stk_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.placed_index = o_idx_r;
  assign out_ch.begin_x      = o_bx_r;
  assign out_ch.begin_y      = o_by_r;
  assign out_ch.end_x        = o_ex_r;
  assign out_ch.end_y        = o_ey_r;
  assign out_ch.atlas_width  = o_aw_r;
  assign out_ch.atlas_height = o_ah_r;
  assign out_ch.atlas_idle   = o_idle_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !idle_r |-> free_r <= full) else $error("free count above atlas area");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(stk_cnt_r) <= MAX_ENTRIES) && (32'(issued_r) <= MAX_ENTRIES))
    else $error("index counters out of range");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    occ_busy |-> !occ_cmd.rd && !occ_cmd.wr) else $error("bitmap access during clear");
  a_placed_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r == ST_PLACED) |-> (o_ex_r >= o_bx_r && o_ey_r >= o_by_r))
    else $error("placed corners out of order");

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the bitmap rectangle allocator: directed table and tests, then random phases.
`default_nettype none
module tb;
  import bra_pkg::*;

  localparam int MAXLOG   = 10;
  localparam int NENT     = 64;
  localparam int WDOG_MAX = 500000;

  typedef struct packed {
    status_t                 status;
    logic signed [IDX_W-1:0] placed_index;
    logic [COORD_W-1:0]      begin_x;
    logic [COORD_W-1:0]      begin_y;
    logic [COORD_W-1:0]      end_x;
    logic [COORD_W-1:0]      end_y;
    logic [ASIZE_W-1:0]      atlas_width;
    logic [ASIZE_W-1:0]      atlas_height;
    logic                    atlas_idle;
  } alloc_res_t;

  typedef struct {
    int      cfg;     // write both default exponents before the row, -1 for none
    logic    cmd;
    int      w;
    int      h;
    int      idx;
    bit      typed;
    status_t st;
    bit      idle;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EXP_W-1:0]     cfg_data;

  bra_in_if  in_ch();
  bra_out_if out_ch();

  bitmap_rectangle_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Allocator state as predicted
  logic [EXP_W-1:0] def_wlog, def_hlog;
  bit               at_idle;
  int unsigned      wexp, hexp, free_px, stk_cnt, issued;
  bit               occ [0:1048575];
  int unsigned      ent_bx [NENT], ent_by [NENT], ent_ex [NENT], ent_ey [NENT];
  bit               ent_live [NENT];
  int unsigned      freed_stk [NENT];

  alloc_res_t expected_q [$];
  int  errors = 0, n_beats = 0, n_results = 0, n_placed = 0, n_full = 0, n_release = 0;
  bit  quiet = 0, hold_req = 0;
  int  hold_left = 0, gap_left = 0, wdog = 0;

  function automatic int unsigned clamp_log(int unsigned e);
    return e > MAXLOG ? MAXLOG : e;
  endfunction

  function automatic int unsigned grow_log(int unsigned d, int unsigned size);
    int unsigned p, dc;
    p = 0;
    dc = clamp_log(d);
    if (size <= (1 << dc)) return dc;
    while (p < MAXLOG && size > (1 << p)) p++;
    return p;
  endfunction

  function automatic alloc_res_t make_res(status_t st, int idx, int unsigned bx, by, ex, ey);
    alloc_res_t r;
    r.status       = st;
    r.placed_index = IDX_W'(idx);
    r.begin_x      = COORD_W'(bx);
    r.begin_y      = COORD_W'(by);
    r.end_x        = COORD_W'(ex);
    r.end_y        = COORD_W'(ey);
    r.atlas_width  = ASIZE_W'(1 << wexp);
    r.atlas_height = ASIZE_W'(1 << hexp);
    r.atlas_idle   = at_idle;
    return r;
  endfunction

  function automatic void release_atlas();
    at_idle = 1;
    wexp = clamp_log(def_wlog);
    hexp = clamp_log(def_hlog);
    free_px = 0;
    stk_cnt = 0;
    issued = 0;
    for (int i = 0; i < NENT; i++) ent_live[i] = 0;
  endfunction

  function automatic void set_default(logic [CFG_IDX_W-1:0] ri, logic [EXP_W-1:0] v);
    if (ri == REG_DEF_WIDTH) def_wlog = v;
    else def_hlog = v;
    if (at_idle) begin
      wexp = clamp_log(def_wlog);
      hexp = clamp_log(def_hlog);
    end
  endfunction

  function automatic alloc_res_t place_rect(int unsigned w, int unsigned h);
    int unsigned aw, ah, x, y, r, c;
    int idx;
    bit clash;
    if (at_idle) begin
      at_idle = 0;
      wexp = grow_log(def_wlog, w);
      hexp = grow_log(def_hlog, h);
      for (int i = 0; i < (1 << (wexp + hexp)); i++) occ[i] = 0;
      free_px = 1 << (wexp + hexp);
    end
    aw = 1 << wexp;
    ah = 1 << hexp;
    if (w == 0 || h == 0 || w * h > free_px || w > aw || h > ah)
      return make_res(ST_NO_ROOM, -1, 0, 0, 0, 0);
    for (y = 0; y + h <= ah; y++) begin
      for (x = 0; x + w <= aw; x++) begin
        clash = 0;
        if (occ[y * aw + x]) continue;
        for (r = y; r < y + h && !clash; r++)
          for (c = x; c < x + w; c++)
            if (occ[r * aw + c]) begin
              clash = 1;
              x = c;  // skip past the conflicting column
              break;
            end
        if (clash) continue;
        if (stk_cnt > 0) begin
          stk_cnt--;
          idx = freed_stk[stk_cnt] % NENT;
        end else if (issued < NENT) begin
          idx = issued;
          issued++;
        end else begin
          return make_res(ST_FULL, -1, 0, 0, 0, 0);
        end
        for (r = y; r < y + h; r++)
          for (c = x; c < x + w; c++) occ[r * aw + c] = 1;
        free_px -= w * h;
        ent_bx[idx] = x;
        ent_by[idx] = y;
        ent_ex[idx] = x + w - 1;
        ent_ey[idx] = y + h - 1;
        ent_live[idx] = 1;
        return make_res(ST_PLACED, idx, x, y, x + w - 1, y + h - 1);
      end
    end
    return make_res(ST_NO_ROOM, -1, 0, 0, 0, 0);
  endfunction

  function automatic alloc_res_t free_rect(logic [IDX_W-1:0] raw);
    int unsigned i, aw;
    if (raw[IDX_W-1] || raw >= NENT || !ent_live[raw] || at_idle)
      return make_res(ST_DELETED, -1, 0, 0, 0, 0);
    i = raw;
    aw = 1 << wexp;
    for (int unsigned r = ent_by[i]; r <= ent_ey[i]; r++)
      for (int unsigned c = ent_bx[i]; c <= ent_ex[i]; c++) begin
        occ[(r * aw + c) % 1048576] = 0;
        free_px++;
      end
    ent_live[i] = 0;
    if (stk_cnt < NENT) begin
      freed_stk[stk_cnt] = i;
      stk_cnt++;
    end
    if (free_px >= (1 << (wexp + hexp))) begin
      release_atlas();
      return make_res(ST_DEL_IDLE, -1, 0, 0, 0, 0);
    end
    return make_res(ST_DELETED, -1, 0, 0, 0, 0);
  endfunction

  // Result sink: random back-pressure, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_req  <= 0;
      hold_left <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      gap_left <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alloc_res_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.placed_index, out_ch.begin_x, out_ch.begin_y,
              out_ch.end_x, out_ch.end_y, out_ch.atlas_width, out_ch.atlas_height,
              out_ch.atlas_idle};
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $realtime, got);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.placed_index !== want.placed_index ||
            got.begin_x !== want.begin_x || got.begin_y !== want.begin_y ||
            got.end_x !== want.end_x || got.end_y !== want.end_y ||
            got.atlas_width !== want.atlas_width || got.atlas_height !== want.atlas_height ||
            got.atlas_idle !== want.atlas_idle) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog == WDOG_MAX) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with the beat taken
  task automatic send_beat(logic cmd, int w, int h, int idx, bit typed, status_t st, bit idle);
    alloc_res_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.rect_width  <= RECT_W'(w);
    in_ch.rect_height <= RECT_W'(h);
    in_ch.entry_index <= IDX_W'(idx);
    do @(posedge clk); while (!in_ch.ready);
    e = (cmd == CMD_ADD) ? place_rect(w[RECT_W-1:0], h[RECT_W-1:0]) : free_rect(idx[IDX_W-1:0]);
    if (typed) begin
      e.status     = st;
      e.atlas_idle = idle;
    end
    if (e.status == ST_PLACED) n_placed++;
    if (e.status == ST_FULL) n_full++;
    if (e.status == ST_DEL_IDLE) n_release++;
    expected_q = {expected_q, e};
    n_beats++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_defaults(logic [EXP_W-1:0] wl, logic [EXP_W-1:0] hl);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_DEF_WIDTH; cfg_data <= wl;
    @(negedge clk);
    set_default(REG_DEF_WIDTH, wl);
    cfg_index <= REG_DEF_HEIGHT; cfg_data <= hl;
    @(negedge clk);
    set_default(REG_DEF_HEIGHT, hl);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int n, int wl, int hl, bit flush);
    int q [$];
    int w, h, side_w, side_h;
    side_w = 1 << wl;
    side_h = 1 << hl;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        q.delete();
        for (int i = 0; i < NENT; i++) if (ent_live[i]) q = {q, i};
        if (q.size() != 0 && $urandom_range(0, 4) != 0)
          send_beat(CMD_DELETE, 0, 0, q[$urandom_range(0, q.size() - 1)], 0, ST_PLACED, 0);
        else
          send_beat(CMD_DELETE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 127), 0, ST_PLACED, 0);
      end else begin
        case ($urandom_range(0, 19))
          0: begin w = $urandom_range(1, 2047); h = $urandom_range(1, 2); end
          1: begin w = $urandom_range(1, 2); h = $urandom_range(1, 2047); end
          2, 3: begin w = $urandom_range(1, 2 * side_w); h = $urandom_range(1, 2 * side_h); end
          default: begin
            w = $urandom_range(1, (side_w > 8) ? side_w / 2 : side_w);
            h = $urandom_range(1, (side_h > 8) ? side_h / 2 : side_h);
          end
        endcase
        send_beat(CMD_ADD, w, h, $urandom_range(0, 127), 0, ST_PLACED, 0);
      end
    end
    if (flush)
      for (int i = 0; i < NENT; i++)
        if (ent_live[i]) send_beat(CMD_DELETE, 0, 0, i, 0, ST_PLACED, 0);
  endtask

  dir_row_t dir_rows [$];

  initial begin
    int wls [10] = '{3, 5, 2, 4, 0, 5, 1, 4, 3, 2};
    int hls [10] = '{3, 2, 5, 4, 3, 5, 1, 2, 0, 4};
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_DEF_WIDTH; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.command = CMD_ADD;
    in_ch.rect_width = '0; in_ch.rect_height = '0; in_ch.entry_index = '0;
    out_ch.ready = 1'b0;
    def_wlog = DEF_LOG2_RESET;
    def_hlog = DEF_LOG2_RESET;
    release_atlas();

    dir_rows = '{
      '{-1, CMD_ADD,    2047, 2047,  0, 1, ST_NO_ROOM,  0},  // growth saturates, stays open
      '{-1, CMD_ADD,       0,    5,  0, 1, ST_NO_ROOM,  0},  // zero width
      '{-1, CMD_ADD,       1,    1,  0, 1, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0, -1, 1, ST_DELETED,  0},  // negative index
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DEL_IDLE, 1},
      '{-1, CMD_ADD,    1024,    1,  0, 0, ST_PLACED,   0},
      '{-1, CMD_ADD,       1, 1024,  0, 1, ST_NO_ROOM,  0},
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DEL_IDLE, 1},
      '{-1, CMD_ADD,       1, 1024,  0, 0, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0, 63, 1, ST_DELETED,  0},  // never issued
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DEL_IDLE, 1},
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DELETED,  1},  // delete while idle
      '{ 4, CMD_ADD,      16,   16,  0, 1, ST_PLACED,   0},
      '{-1, CMD_ADD,       1,    1,  0, 1, ST_NO_ROOM,  0},
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DEL_IDLE, 1},
      '{-1, CMD_ADD,       3,    3,  0, 0, ST_PLACED,   0},
      '{-1, CMD_ADD,       3,    3,  0, 0, ST_PLACED,   0},
      '{-1, CMD_ADD,       5,    2,  0, 0, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0,  1, 0, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0,  1, 1, ST_DELETED,  0},  // already free
      '{-1, CMD_ADD,       2,    2,  0, 0, ST_PLACED,   0},  // reuses a freed index
      '{-1, CMD_DELETE,    0,    0,  0, 0, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0,  1, 0, ST_PLACED,   0},
      '{-1, CMD_DELETE,    0,    0,  2, 1, ST_DEL_IDLE, 1},
      '{ 0, CMD_ADD,       1,    1,  0, 1, ST_PLACED,   0},
      '{-1, CMD_ADD,       1,    1,  0, 1, ST_NO_ROOM,  0},
      '{-1, CMD_DELETE,    0,    0,  0, 1, ST_DEL_IDLE, 1}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0)
        write_defaults(EXP_W'(dir_rows[i].cfg), EXP_W'(dir_rows[i].cfg));
      send_beat(dir_rows[i].cmd, dir_rows[i].w, dir_rows[i].h, dir_rows[i].idx,
                dir_rows[i].typed, dir_rows[i].st, dir_rows[i].idle);
    end

    // Oversized register value clamps to the largest atlas
    write_defaults(4'hf, 4'hf);
    send_beat(CMD_ADD, 1, 1, 0, 0, ST_PLACED, 0);
    send_beat(CMD_DELETE, 0, 0, 0, 0, ST_PLACED, 0);

    // Exhaust the entry table, then free it all
    write_defaults(4'd4, 4'd4);
    for (int i = 0; i <= NENT; i++) send_beat(CMD_ADD, 1, 1, 0, 0, ST_PLACED, 0);
    for (int i = 0; i < NENT; i++) send_beat(CMD_DELETE, 0, 0, i, 0, ST_PLACED, 0);

    for (int p = 0; p < 10; p++) begin
      write_defaults(EXP_W'(wls[p]), EXP_W'(hls[p]));
      if (p == 3) hold_req = 1;
      if (p == 9) quiet = 1;
      random_phase(40, wls[p], hls[p], p % 2 == 0);
    end

    drain();
    repeat (50) @(negedge clk);
    $display("tb: %0d input beats, %0d results, %0d placed, %0d table-full, %0d releases",
             n_beats, n_results, n_placed, n_full, n_release);
    $display("tb: defaults from 0 to 15 per side, with growth, clamping and back-pressure");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[bitmap_rectangle_allocator.f]
design/bra_pkg.sv
design/bra_if.sv
design/bra_occ_mem.sv
design/bra_tbl.sv
design/bitmap_rectangle_allocator.sv
dv/tb.sv
